FILE: sv/assert_macros.svh
// Assertion macros of the escaped frame receiver RTL, used by efr_core.
// Depends on nothing; the bodies are empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define EFR_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("efr assertion failed");
`define EFR_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
		else $error("efr assertion failed");
`else
`define EFR_ASSERT(label, clk, rst_n, prop)
`define EFR_ASSERT_NEXT(label, clk, rst_n, cond, prop)
`endif
`endif

FILE: sv/efr_pkg.sv
// Package of the escaped frame receiver: codes, constants and the result type.
// Used by every module of the block; depends on nothing.
`default_nettype none
package efr_pkg;
	localparam int TICK_W = 20;
	localparam int ADDR_W = 2;

	localparam logic [7:0] SYNC_BYTE = 8'hE0;
	localparam logic [7:0] ESC_BYTE = 8'hD0;
	localparam logic [TICK_W-1:0] TIMEOUT_RESET = 20'd200000;
	localparam logic [TICK_W-1:0] TICK_MAX = 20'hFFFFF;
	localparam logic [ADDR_W-1:0] REG_TIMEOUT = 2'd0;

	typedef enum logic {
		CMD_BYTE = 1'b0,
		CMD_TICK = 1'b1
	} cmd_t;

	typedef enum logic {
		KIND_STORED = 1'b0,
		KIND_ACCEPTED = 1'b1
	} kind_t;

	typedef struct packed {
		logic valid;
		kind_t kind;
		logic [7:0] byte_index;
		logic [7:0] byte_value;
		logic [7:0] frame_length;
	} result_t;
endpackage
`default_nettype wire

FILE: sv/efr_cfg.sv
// APB register file of the escaped frame receiver: holds timeout_ticks.
// Depends on efr_pkg.
`default_nettype none
module efr_cfg (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic psel,
	input  wire logic penable,
	input  wire logic pwrite,
	input  wire logic [efr_pkg::ADDR_W-1:0] paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	output logic [efr_pkg::TICK_W-1:0] timeout_ticks
);
	logic [efr_pkg::TICK_W-1:0] timeout_q;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= efr_pkg::TIMEOUT_RESET;
		end else if (psel && penable && pwrite && paddr == efr_pkg::REG_TIMEOUT) begin
			timeout_q <= pwdata[efr_pkg::TICK_W-1:0];
		end
	end

	always_comb begin
		prdata = 32'd0;
		if (paddr == efr_pkg::REG_TIMEOUT) begin
			prdata = {{(32-efr_pkg::TICK_W){1'b0}}, timeout_q};
		end
	end

	assign timeout_ticks = timeout_q;
endmodule
`default_nettype wire

FILE: sv/efr_core.sv
// Deframing state and step logic of the escaped frame receiver.
// Depends on efr_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module efr_core (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic item_valid,
	input  wire logic advance,
	input  wire efr_pkg::cmd_t command,
	input  wire logic [7:0] rx_byte,
	input  wire logic [efr_pkg::TICK_W-1:0] timeout_ticks,
	output efr_pkg::result_t result
);
	logic active_q, active_n;
	logic esc_q, esc_n;
	logic [7:0] count_q, count_n;
	logic [7:0] sum_q, sum_n;
	logic [7:0] len_q, len_n;
	logic [efr_pkg::TICK_W-1:0] elapsed_q, elapsed_n;
	logic [8:0] value;

	always_comb begin
		active_n = active_q;
		esc_n = esc_q;
		count_n = count_q;
		sum_n = sum_q;
		len_n = len_q;
		elapsed_n = elapsed_q;
		result = '0;
		result.kind = efr_pkg::KIND_STORED;
		value = {1'b0, rx_byte} + {8'd0, esc_q};
		if (command == efr_pkg::CMD_TICK) begin
			if (active_q) begin
				if (elapsed_q != efr_pkg::TICK_MAX) begin
					elapsed_n = elapsed_q + {{(efr_pkg::TICK_W-1){1'b0}}, 1'b1};
				end
				if (elapsed_n > timeout_ticks) begin
					active_n = 1'b0;
				end
			end
		end else if (rx_byte == efr_pkg::SYNC_BYTE) begin
			active_n = 1'b1;
			esc_n = 1'b0;
			count_n = 8'd0;
			sum_n = 8'd0;
			elapsed_n = '0;
		end else if (active_q) begin
			if (rx_byte == efr_pkg::ESC_BYTE) begin
				esc_n = 1'b1;
			end else begin
				esc_n = 1'b0;
				if (count_q != 8'd0 && count_q == len_q) begin
					if (value == {1'b0, sum_q}) begin
						active_n = 1'b0;
						result.valid = item_valid;
						result.kind = efr_pkg::KIND_ACCEPTED;
						result.byte_index = count_q;
						result.byte_value = sum_q;
						result.frame_length = len_q;
					end
				end else begin
					if (count_q == 8'd0) begin
						len_n = value[7:0];
					end
					count_n = count_q + 8'd1;
					sum_n = sum_q + value[7:0];
					result.valid = item_valid;
					result.byte_index = count_q;
					result.byte_value = value[7:0];
					result.frame_length = len_n;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			esc_q <= 1'b0;
			count_q <= 8'd0;
			sum_q <= 8'd0;
			len_q <= 8'd0;
			elapsed_q <= '0;
		end else if (advance) begin
			active_q <= active_n;
			esc_q <= esc_n;
			count_q <= count_n;
			sum_q <= sum_n;
			len_q <= len_n;
			elapsed_q <= elapsed_n;
		end
	end

	`EFR_ASSERT_NEXT(a_accept_closes, clk, arst_n, advance && result.valid && result.kind == efr_pkg::KIND_ACCEPTED, !active_q)
	`EFR_ASSERT_NEXT(a_sync_opens, clk, arst_n, advance && command == efr_pkg::CMD_BYTE && rx_byte == efr_pkg::SYNC_BYTE, active_q && !esc_q && count_q == 8'd0 && sum_q == 8'd0 && elapsed_q == '0)
	`EFR_ASSERT_NEXT(a_hold_when_idle, clk, arst_n, !advance, $stable({active_q, esc_q, count_q, sum_q, len_q, elapsed_q}))
	`EFR_ASSERT(a_result_needs_item, clk, arst_n, !result.valid || (item_valid && command == efr_pkg::CMD_BYTE))
endmodule
`default_nettype wire

FILE: sv/efr_out.sv
// Output register of the escaped frame receiver: holds one result for the master side.
// Depends on efr_pkg.
`default_nettype none
module efr_out (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic load,
	input  wire efr_pkg::result_t result,
	output logic free,
	output logic m_tvalid,
	input  wire logic m_tready,
	output logic [23:0] m_tdata,
	output logic [0:0] m_tuser
);
	logic valid_q;
	logic [23:0] data_q;
	logic kind_q;

	assign free = !valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (m_tready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= {result.frame_length, result.byte_value, result.byte_index};
			kind_q <= result.kind;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata = data_q;
	assign m_tuser = kind_q;
endmodule
`default_nettype wire

FILE: sv/escaped_frame_receiver_top.sv
// Escaped frame receiver: deframes a sync/escape byte stream and checks the frame sum.
// Ports: slave stream in (s_*), master stream out (m_*), APB register port.
// Inputs come as bytes (s_tuser = 0) or time ticks (s_tuser = 1). A byte 0xE0 opens a
// frame; 0xD0 escapes the next byte, which is then taken one larger. The first frame
// byte is the length. Each stored byte leaves as a result with m_tuser = 0 and its
// index; once length bytes are stored, a byte equal to the 8-bit sum leaves a result
// with m_tuser = 1 and closes the frame. Ticks age an open frame, and it is dropped
// once more than timeout_ticks (register 0, byte address 0) have passed.
// A word accepted is held in the input register, and its result is loaded into the
// output register when the item advances; that register drives m_tvalid. One item is
// taken every cycle unless a result waits for the output register; the frame state is
// updated in one step per item, which sets that rate.
// While m_tready is low and a result waits, the next item that gives no result still
// passes; an item that gives a result waits in the input register, and s_tready
// falls until the output register frees.
// Reset clears the frame state and the valid flags and sets timeout_ticks to 200000.
`default_nettype none
module escaped_frame_receiver_top (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic s_tvalid,
	output logic s_tready,
	input  wire logic [7:0] s_tdata,   // [7:0] rx_byte
	input  wire logic [0:0] s_tuser,   // [0] command
	output logic m_tvalid,
	input  wire logic m_tready,
	output logic [23:0] m_tdata,       // [7:0] byte_index, [15:8] byte_value, [23:16] frame_length
	output logic [0:0] m_tuser,        // [0] kind
	input  wire logic psel,
	input  wire logic penable,
	input  wire logic pwrite,
	input  wire logic [efr_pkg::ADDR_W-1:0] paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	logic valid_s1;
	efr_pkg::cmd_t cmd_s1;
	logic [7:0] byte_s1;
	logic advance;
	logic out_free;
	logic [efr_pkg::TICK_W-1:0] timeout_ticks;
	efr_pkg::result_t result;

	efr_cfg u_cfg (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.timeout_ticks(timeout_ticks)
	);

	assign advance = valid_s1 && (!result.valid || out_free);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			cmd_s1 <= efr_pkg::cmd_t'(s_tuser[0]);
			byte_s1 <= s_tdata;
		end
	end

	efr_core u_core (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(valid_s1),
		.advance(advance),
		.command(cmd_s1),
		.rx_byte(byte_s1),
		.timeout_ticks(timeout_ticks),
		.result(result)
	);

	efr_out u_out (
		.clk(clk),
		.arst_n(arst_n),
		.load(advance && result.valid),
		.result(result),
		.free(out_free),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);
endmodule
`default_nettype wire

FILE: sim/tb_escaped_frame_receiver_top.sv
// Self-checking testbench of escaped_frame_receiver_top: directed and random byte/tick streams.
// Predicts every result from its own deframer state and checks the output stream in order.
// Depends on efr_pkg and escaped_frame_receiver_top.
`default_nettype none
module tb_escaped_frame_receiver_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int IDLE_CYCLES = 8;

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [7:0] s_tdata;
	logic [0:0] s_tuser;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [23:0] m_tdata;
	logic [0:0] m_tuser;
	logic psel;
	logic penable;
	logic pwrite;
	logic [efr_pkg::ADDR_W-1:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;

	escaped_frame_receiver_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	// Deframer state as the testbench sees it.
	logic [efr_pkg::TICK_W-1:0] rx_timeout = efr_pkg::TIMEOUT_RESET;
	logic rx_active = 1'b0;
	logic rx_escape = 1'b0;
	logic [7:0] rx_count = 8'd0;
	logic [7:0] rx_sum = 8'd0;
	logic [7:0] rx_length = 8'd0;
	logic [efr_pkg::TICK_W-1:0] rx_elapsed = '0;

	efr_pkg::result_t pending_results[$];
	efr_pkg::result_t got;
	efr_pkg::result_t want;
	bit steady = 1'b0;
	int unsigned stall_left = 0;
	int unsigned words_sent = 0;
	int unsigned results_seen = 0;
	int unsigned config_writes = 0;
	int unsigned mismatches = 0;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#10ms;
		$display("tb_escaped_frame_receiver_top: errors");
		$finish;
	end

	function automatic int unsigned pick_gap();
		int unsigned r;
		if (steady) return 0;
		r = $urandom_range(99);
		if (r < 65) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(6, 40);
	endfunction

	function automatic void push_result(efr_pkg::kind_t kind, logic [7:0] index,
		logic [7:0] value);
		efr_pkg::result_t r;
		r.valid = 1'b1;
		r.kind = kind;
		r.byte_index = index;
		r.byte_value = value;
		r.frame_length = rx_length;
		pending_results.push_back(r);
	endfunction

	function automatic void deframe_word(efr_pkg::cmd_t cmd, logic [7:0] data);
		logic [8:0] value;
		logic [7:0] index;
		if (cmd == efr_pkg::CMD_TICK) begin
			if (rx_active) begin
				if (rx_elapsed < efr_pkg::TICK_MAX) rx_elapsed++;
				if (rx_elapsed > rx_timeout) rx_active = 1'b0;
			end
		end else if (data == efr_pkg::SYNC_BYTE) begin
			rx_active = 1'b1;
			rx_count = 8'd0;
			rx_sum = 8'd0;
			rx_escape = 1'b0;
			rx_elapsed = '0;
		end else if (rx_active) begin
			if (data == efr_pkg::ESC_BYTE) begin
				rx_escape = 1'b1;
			end else begin
				value = {1'b0, data} + (rx_escape ? 9'd1 : 9'd0);
				rx_escape = 1'b0;
				if (rx_count != 8'd0 && rx_count == rx_length) begin
					if (value == {1'b0, rx_sum}) begin
						rx_active = 1'b0;
						push_result(efr_pkg::KIND_ACCEPTED, rx_count, rx_sum);
					end
				end else begin
					index = rx_count;
					if (index == 8'd0) rx_length = value[7:0];
					rx_count = rx_count + 8'd1;
					rx_sum = rx_sum + value[7:0];
					push_result(efr_pkg::KIND_STORED, index, value[7:0]);
				end
			end
		end
	endfunction

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			results_seen++;
			got.valid = 1'b1;
			got.kind = efr_pkg::kind_t'(m_tuser[0]);
			got.byte_index = m_tdata[7:0];
			got.byte_value = m_tdata[15:8];
			got.frame_length = m_tdata[23:16];
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Unexpected result: kind %0d index %0d value %0d length %0d",
						got.kind, got.byte_index, got.byte_value, got.frame_length);
			end else begin
				want = pending_results.pop_front();
				if (got.kind !== want.kind || got.byte_index !== want.byte_index ||
				    got.byte_value !== want.byte_value ||
				    got.frame_length !== want.frame_length) begin
					mismatches++;
					if (mismatches <= 10)
						$display("Result %0d: expected kind %0d index %0d value %0d length %0d,",
							results_seen, want.kind, want.byte_index, want.byte_value,
							want.frame_length,
							" got kind %0d index %0d value %0d length %0d",
							got.kind, got.byte_index, got.byte_value, got.frame_length);
				end
			end
		end
		if (stall_left == 0) stall_left = pick_gap();
		if (stall_left != 0) begin
			m_tready <= 1'b0;
			stall_left--;
		end else begin
			m_tready <= 1'b1;
		end
	end

	task automatic send_word(input efr_pkg::cmd_t cmd, input logic [7:0] data);
		int unsigned gap;
		gap = pick_gap();
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tdata <= data;
		do @(posedge clk); while (!s_tready);
		deframe_word(cmd, data);
		words_sent++;
	endtask

	// Sends a value so that it is stored as given, escaping it where it must or may be.
	task automatic send_value(input logic [7:0] value);
		logic [7:0] lower;
		lower = value - 8'd1;
		if (value == efr_pkg::SYNC_BYTE || value == efr_pkg::ESC_BYTE ||
		    (value != 8'h00 && lower != efr_pkg::SYNC_BYTE && lower != efr_pkg::ESC_BYTE &&
		     $urandom_range(99) < 15)) begin
			send_word(efr_pkg::CMD_BYTE, efr_pkg::ESC_BYTE);
			send_word(efr_pkg::CMD_BYTE, lower);
		end else begin
			send_word(efr_pkg::CMD_BYTE, value);
		end
	endtask

	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (IDLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_timeout(input logic [efr_pkg::TICK_W-1:0] ticks);
		wait_idle();
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= efr_pkg::REG_TIMEOUT;
		pwdata <= {12'($urandom), ticks};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		rx_timeout = ticks;
		config_writes++;
	endtask

	task automatic test_directed_frames();
		send_word(efr_pkg::CMD_TICK, 8'h00);
		send_word(efr_pkg::CMD_BYTE, 8'h41);
		send_word(efr_pkg::CMD_BYTE, efr_pkg::SYNC_BYTE);
		send_word(efr_pkg::CMD_BYTE, efr_pkg::ESC_BYTE);
		send_word(efr_pkg::CMD_BYTE, efr_pkg::ESC_BYTE);
		send_word(efr_pkg::CMD_BYTE, 8'h02);
		send_word(efr_pkg::CMD_TICK, 8'hFF);
		send_word(efr_pkg::CMD_BYTE, 8'hFF);
		send_word(efr_pkg::CMD_BYTE, efr_pkg::ESC_BYTE);
		send_word(efr_pkg::CMD_BYTE, 8'hFF);
		send_word(efr_pkg::CMD_BYTE, 8'h07);
		send_word(efr_pkg::CMD_BYTE, efr_pkg::ESC_BYTE);
		send_word(efr_pkg::CMD_BYTE, 8'h01);
		// The sum is zero here, so only the escaped 0xFF could look like a match.
		send_word(efr_pkg::CMD_BYTE, efr_pkg::SYNC_BYTE);
		send_word(efr_pkg::CMD_BYTE, 8'h02);
		send_word(efr_pkg::CMD_BYTE, 8'hFE);
		send_word(efr_pkg::CMD_BYTE, efr_pkg::ESC_BYTE);
		send_word(efr_pkg::CMD_BYTE, 8'hFF);
		send_word(efr_pkg::CMD_BYTE, 8'h00);
		send_word(efr_pkg::CMD_BYTE, efr_pkg::SYNC_BYTE);
		send_word(efr_pkg::CMD_BYTE, efr_pkg::ESC_BYTE);
		send_word(efr_pkg::CMD_BYTE, efr_pkg::SYNC_BYTE);
		send_word(efr_pkg::CMD_BYTE, 8'h01);
		send_word(efr_pkg::CMD_BYTE, 8'h01);
	endtask

	task automatic test_frame_timeout();
		set_timeout('0);
		send_word(efr_pkg::CMD_BYTE, efr_pkg::SYNC_BYTE);
		send_word(efr_pkg::CMD_TICK, 8'h00);
		send_word(efr_pkg::CMD_BYTE, 8'h05);
		set_timeout(20'd1);
		send_word(efr_pkg::CMD_BYTE, efr_pkg::SYNC_BYTE);
		send_word(efr_pkg::CMD_TICK, 8'h00);
		send_word(efr_pkg::CMD_BYTE, 8'h01);
		send_word(efr_pkg::CMD_TICK, 8'h00);
		send_word(efr_pkg::CMD_BYTE, 8'h01);
		// With the largest timeout the frame survives a few ticks.
		set_timeout(efr_pkg::TICK_MAX);
		steady = 1'b1;
		send_word(efr_pkg::CMD_BYTE, efr_pkg::SYNC_BYTE);
		repeat (4) send_word(efr_pkg::CMD_TICK, 8'h00);
		steady = 1'b0;
		send_word(efr_pkg::CMD_BYTE, 8'h01);
		send_word(efr_pkg::CMD_BYTE, 8'h01);
	endtask

	task automatic test_zero_length();
		int unsigned i;
		set_timeout(efr_pkg::TIMEOUT_RESET);
		send_word(efr_pkg::CMD_BYTE, efr_pkg::SYNC_BYTE);
		send_value(8'h00);
		for (i = 0; i < 255; i++) send_value(8'($urandom));
		// The count has wrapped, so this byte becomes the new length.
		send_value(8'h02);
		send_value(8'($urandom));
		send_value(rx_sum);
	endtask

	task automatic send_random_frame();
		int unsigned len;
		int unsigned r;
		int unsigned i;
		r = $urandom_range(99);
		if (r < 10) len = 1;
		else if (r < 85) len = $urandom_range(2, 8);
		else len = $urandom_range(9, 40);
		send_word(efr_pkg::CMD_BYTE, efr_pkg::SYNC_BYTE);
		for (i = 0; i < len; i++) begin
			if ($urandom_range(99) < 4) send_word(efr_pkg::CMD_TICK, 8'($urandom));
			if (i == 0) begin
				send_value(8'(len));
			end else if ($urandom_range(99) < 6) begin
				send_word(efr_pkg::CMD_BYTE, efr_pkg::ESC_BYTE);
				send_word(efr_pkg::CMD_BYTE, 8'hFF);
			end else begin
				send_value(8'($urandom));
			end
		end
		r = $urandom_range(99);
		if (r >= 10) begin
			if (r < 30) begin
				send_value(rx_sum + 8'($urandom_range(1, 255)));
			end else if (r < 38) begin
				send_word(efr_pkg::CMD_BYTE, efr_pkg::ESC_BYTE);
				send_word(efr_pkg::CMD_BYTE, 8'hFF);
			end
			send_value(rx_sum);
		end
	endtask

	task automatic send_noise();
		int unsigned n;
		int unsigned i;
		n = $urandom_range(1, 6);
		for (i = 0; i < n; i++) begin
			if ($urandom_range(99) < 30) send_word(efr_pkg::CMD_TICK, 8'($urandom));
			else send_word(efr_pkg::CMD_BYTE, 8'($urandom));
		end
	endtask

	task automatic test_random_traffic();
		logic [efr_pkg::TICK_W-1:0] timeouts[6];
		int unsigned p;
		int unsigned f;
		timeouts = '{efr_pkg::TIMEOUT_RESET, '0, 20'd1, 20'd7, 20'($urandom),
			efr_pkg::TICK_MAX};
		for (p = 0; p < 6; p++) begin
			set_timeout(timeouts[p]);
			for (f = 0; f < 9; f++) begin
				steady = ($urandom_range(99) < 20);
				if ($urandom_range(99) < 15) send_noise();
				send_random_frame();
			end
			steady = 1'b0;
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= 8'h00;
		s_tuser <= efr_pkg::CMD_BYTE;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= efr_pkg::REG_TIMEOUT;
		pwdata <= 32'd0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_frames();
		test_frame_timeout();
		test_zero_length();
		test_random_traffic();
		wait_idle();
		$display("Sent %0d words and checked %0d results across %0d timeout register writes.",
			words_sent, results_seen, config_writes);
		$display("Mismatched or unexpected results: %0d.", mismatches);
		if (mismatches == 0) begin
			$display("tb_escaped_frame_receiver_top: clean");
		end else begin
			$display("tb_escaped_frame_receiver_top: errors");
		end
		$finish;
	end
endmodule
`default_nettype wire

FILE: sim.f
+incdir+sv
sv/efr_pkg.sv
sv/efr_cfg.sv
sv/efr_core.sv
sv/efr_out.sv
sv/escaped_frame_receiver_top.sv
sim/tb_escaped_frame_receiver_top.sv
